FILE: rtl/core/pidpwm_pkg.sv
// ----------------------------------------------------------------------------
// pidpwm_pkg: shared definitions for the PID PWM voltage regulator
// Widths, register indexes, operation codes and fixed constants.
// ----------------------------------------------------------------------------
package pidpwm_pkg;

  // Default sizes of the ADC samples and of the gain fraction.
  localparam int unsigned ADC_BITS_DEF       = 10;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;

  // Fixed widths of the register file and of the controller state.
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned ERR_SUM_W   = 17;
  localparam int unsigned ACC_W       = 18;
  localparam int unsigned DUTY_W      = 8;

  // Duty decrement applied on each enabled overvoltage sample while the duty is nonzero.
  localparam logic [DUTY_W-1:0] BACKOFF_STEP = 8'd5;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_PROP      = 3'd0,
    CFG_GAIN_INTEG     = 3'd1,
    CFG_GAIN_DERIV     = 3'd2,
    CFG_INTEG_LIMIT    = 3'd3,
    CFG_TARGET_LOW     = 3'd4,
    CFG_TARGET_HIGH    = 3'd5,
    CFG_OVERVOLT_LIMIT = 3'd6,
    CFG_DUTY_LIMIT     = 3'd7
  } cfg_index_e;

  // Request operation codes.
  typedef enum logic {
    OP_VOLTAGE = 1'b0,
    OP_ADJUST  = 1'b1
  } op_e;

endpackage

FILE: rtl/core/pid_pwm_voltage_regulator_top.sv
// ----------------------------------------------------------------------------
// pid_pwm_voltage_regulator_top: PID PWM duty regulator for a lamp
// Knob samples set the target voltage; voltage samples disable, back off
// or run one clamped PID step on the PWM duty.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless the input stalls, and
// returns one result per request: the request is captured in an input
// register, and when the result register is free the three gain multiplies,
// their sum and the duty clamp (or the knob scaling) run as one combinational
// pass that updates the controller state and loads the result register. That
// pass sets the clock period. A request is still taken while a result waits on
// a stalled output; the input stalls only when both registers are full. All
// voltages are raw ADC counts. Configuration registers are written through a
// plain write port and should only be changed while no request is in flight.
module pid_pwm_voltage_regulator_top #(
  parameter int unsigned ADC_BITS       = pidpwm_pkg::ADC_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = pidpwm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [pidpwm_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [pidpwm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [ADC_BITS-1:0]                 reading_i,
  input  logic                                enabled_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pidpwm_pkg::DUTY_W-1:0]       duty_o,
  output logic [ADC_BITS-1:0]                 target_o,
  output logic                                backing_off_o
);

  localparam int unsigned GW   = pidpwm_pkg::GAIN_W;
  localparam int unsigned EW   = ADC_BITS + 1;
  localparam int unsigned RW   = ADC_BITS + 2;
  localparam int unsigned SW   = pidpwm_pkg::ERR_SUM_W;
  localparam int unsigned AW   = pidpwm_pkg::ACC_W;
  localparam int unsigned DW   = pidpwm_pkg::DUTY_W;
  localparam int unsigned PW_P = GW + EW;
  localparam int unsigned PW_I = GW + SW;
  localparam int unsigned PW_D = GW + RW;
  localparam int unsigned PW_MAX = (PW_P > PW_I) ? ((PW_P > PW_D) ? PW_P : PW_D)
                                                 : ((PW_I > PW_D) ? PW_I : PW_D);
  localparam int unsigned SUM_W = PW_MAX + 2;
  localparam int unsigned QW    = SUM_W - GAIN_FRAC_BITS;
  localparam logic [ADC_BITS-1:0] AdcMask = '1;

  // Configuration registers
  logic signed [GW-1:0]                   gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [pidpwm_pkg::LIMIT_W-1:0]         integ_limit_q;
  logic [ADC_BITS-1:0]                    target_low_q, target_high_q, overvolt_limit_q;
  logic [DW-1:0]                          duty_limit_q;

  // Controller state
  logic [DW-1:0]         duty_now_q, duty_now_d;
  logic signed [EW-1:0]  last_err_q, last_err_d;
  logic signed [SW-1:0]  err_sum_q, err_sum_d;
  logic [ADC_BITS-1:0]   target_now_q, target_now_d;
  logic                  backing_d;

  // Input and result registers
  logic                  in_valid_q;
  logic                  in_op_q;
  logic [ADC_BITS-1:0]   in_reading_q;
  logic                  in_enabled_q;
  logic                  out_valid_q;
  logic [DW-1:0]         out_duty_q;
  logic [ADC_BITS-1:0]   out_target_q;
  logic                  out_back_q;

  logic out_ready;
  logic fire;

  // Handshake: the result register frees up when empty or being taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q      <= '0;
      gain_integ_q     <= '0;
      gain_deriv_q     <= '0;
      integ_limit_q    <= '0;
      target_low_q     <= '0;
      target_high_q    <= '0;
      overvolt_limit_q <= '0;
      duty_limit_q     <= '0;
    end else if (cfg_we_i) begin
      case (pidpwm_pkg::cfg_index_e'(cfg_index_i))
        pidpwm_pkg::CFG_GAIN_PROP:      gain_prop_q      <= cfg_data_i[GW-1:0];
        pidpwm_pkg::CFG_GAIN_INTEG:     gain_integ_q     <= cfg_data_i[GW-1:0];
        pidpwm_pkg::CFG_GAIN_DERIV:     gain_deriv_q     <= cfg_data_i[GW-1:0];
        pidpwm_pkg::CFG_INTEG_LIMIT:
          integ_limit_q <= cfg_data_i[pidpwm_pkg::LIMIT_W-1:0];
        pidpwm_pkg::CFG_TARGET_LOW:     target_low_q     <= cfg_data_i[ADC_BITS-1:0];
        pidpwm_pkg::CFG_TARGET_HIGH:    target_high_q    <= cfg_data_i[ADC_BITS-1:0];
        pidpwm_pkg::CFG_OVERVOLT_LIMIT: overvolt_limit_q <= cfg_data_i[ADC_BITS-1:0];
        pidpwm_pkg::CFG_DUTY_LIMIT:     duty_limit_q     <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_op_q      <= op_i;
      in_reading_q <= reading_i;
      in_enabled_q <= enabled_i;
    end
  end

  // Knob scaling: target_low + span * reading / (2^ADC_BITS - 1), toward zero.
  // The divide by 2^N-1 is a shift plus one correction on the remainder.
  logic signed [EW-1:0]       span;
  logic                       span_neg;
  logic [ADC_BITS-1:0]        span_mag;
  logic [2*ADC_BITS-1:0]      knob_prod;
  logic [ADC_BITS-1:0]        quo_est;
  logic [ADC_BITS:0]          quo_rem;
  logic [ADC_BITS-1:0]        quo;
  logic [ADC_BITS-1:0]        knob_target;

  always_comb begin
    span      = $signed({1'b0, target_high_q}) - $signed({1'b0, target_low_q});
    span_neg  = span[EW-1];
    span_mag  = span_neg ? ADC_BITS'(-span) : span[ADC_BITS-1:0];
    knob_prod = span_mag * in_reading_q;
    quo_est   = knob_prod[2*ADC_BITS-1:ADC_BITS];
    quo_rem   = {1'b0, knob_prod[ADC_BITS-1:0]} + {1'b0, quo_est};
    quo       = (quo_rem >= {1'b0, AdcMask}) ? quo_est + ADC_BITS'(1) : quo_est;
    knob_target = span_neg ? target_low_q - quo : target_low_q + quo;
  end

  // PID step: error, clamped accumulation, rate and the weighted sum.
  logic signed [EW-1:0]     err;
  logic signed [AW-1:0]     acc_raw;
  logic signed [AW-1:0]     lim_pos;
  logic signed [SW-1:0]     acc;
  logic signed [RW-1:0]     rate;
  logic signed [PW_P-1:0]   prod_p;
  logic signed [PW_I-1:0]   prod_i;
  logic signed [PW_D-1:0]   prod_d;
  logic signed [SUM_W-1:0]  pid_sum;
  logic [QW-1:0]            pid_quo;
  logic [DW-1:0]            pid_duty;

  always_comb begin
    err     = $signed({1'b0, target_now_q}) - $signed({1'b0, in_reading_q});
    acc_raw = AW'(err_sum_q) + AW'(err);
    lim_pos = $signed({2'b00, integ_limit_q});
    if (acc_raw < -lim_pos) begin
      acc = SW'(-lim_pos);
    end else if (acc_raw > lim_pos) begin
      acc = SW'(lim_pos);
    end else begin
      acc = SW'(acc_raw);
    end
    rate    = RW'(err) - RW'(last_err_q);
    prod_p  = gain_prop_q * err;
    prod_i  = gain_integ_q * acc;
    prod_d  = gain_deriv_q * rate;
    pid_sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    pid_quo = pid_sum[SUM_W-1:GAIN_FRAC_BITS];
    if (pid_sum[SUM_W-1]) begin
      pid_duty = '0;
    end else if (pid_quo > QW'(duty_limit_q)) begin
      pid_duty = duty_limit_q;
    end else begin
      pid_duty = pid_quo[DW-1:0];
    end
  end

  // Select what this request does to the controller state.
  logic backoff_cond;
  assign backoff_cond = (in_reading_q > overvolt_limit_q) && (duty_now_q != '0);

  always_comb begin
    duty_now_d   = duty_now_q;
    last_err_d   = last_err_q;
    err_sum_d    = err_sum_q;
    target_now_d = target_now_q;
    backing_d    = 1'b0;
    case (pidpwm_pkg::op_e'(in_op_q))
      pidpwm_pkg::OP_ADJUST: begin
        target_now_d = knob_target;
      end
      pidpwm_pkg::OP_VOLTAGE: begin
        if (!in_enabled_q) begin
          duty_now_d = '0;
          last_err_d = '0;
          err_sum_d  = '0;
        end else if (backoff_cond) begin
          duty_now_d = (duty_now_q > pidpwm_pkg::BACKOFF_STEP) ?
                       duty_now_q - pidpwm_pkg::BACKOFF_STEP : '0;
          backing_d  = 1'b1;
        end else begin
          duty_now_d = pid_duty;
          last_err_d = err;
          err_sum_d  = acc;
        end
      end
      default: ;
    endcase
  end

  // Controller state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_now_q   <= '0;
      last_err_q   <= '0;
      err_sum_q    <= '0;
      target_now_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        duty_now_q   <= duty_now_d;
        last_err_q   <= last_err_d;
        err_sum_q    <= err_sum_d;
        target_now_q <= target_now_d;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_duty_q   <= duty_now_d;
      out_target_q <= target_now_d;
      out_back_q   <= backing_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = out_duty_q;
  assign target_o      = out_target_q;
  assign backing_off_o = out_back_q;

`ifndef ASSERT_OFF
  logic pid_fire;
  assign pid_fire = fire && (in_op_q == pidpwm_pkg::OP_VOLTAGE) && in_enabled_q &&
                    !backoff_cond;

  // The input only stalls when both pipeline registers hold a request.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline slot");

  // A PID step never commands more than the duty limit.
  a_duty_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pid_fire |=> (duty_now_q <= $past(duty_limit_q)))
    else $error("PID duty above duty limit");

  // The accumulated error stays inside the integral bound after a PID step.
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pid_fire |=> (($signed(err_sum_q) <= $signed({2'b00, $past(integ_limit_q)})) &&
                  ($signed(err_sum_q) >= -$signed({2'b00, $past(integ_limit_q)}))))
    else $error("error sum outside integral bound");

  // A disabled voltage sample clears duty and controller memory.
  a_disable_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_op_q == pidpwm_pkg::OP_VOLTAGE) && !in_enabled_q) |=>
      ((duty_now_q == '0) && (err_sum_q == '0) && (last_err_q == '0) && (duty_o == '0)))
    else $error("disable did not clear controller state");
`endif

endmodule
